[design/qdps_pkg.sv]
// Shared constants for the quadrature decoder with period-based rate.
// Used by the channel interfaces and the top level; depends on nothing.
package qdps_pkg;

  localparam int DATA_W      = 32;
  localparam int TIME_W      = 32;
  localparam int ACT_W       = 2;
  localparam int DIR_W       = 2;
  localparam int CFG_IDX_W   = 1;

  // Timestamp ring
  localparam int RING_DEPTH  = 8;
  localparam int IDX_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Dividend is (RING_DEPTH-1) * |rate_scale|, quotient has the same width
  localparam int NUM_W       = DATA_W + $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(NUM_W);

  // Item kinds
  localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SNAP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIMEOUT = 1'd1;

  localparam logic [DATA_W-1:0] RATE_SCALE_RST    = 32'hFFFF_C000;  // -0.25 in Q16.16
  localparam logic [TIME_W-1:0] STALL_TIMEOUT_RST = 32'd65535;

  localparam logic [DATA_W-1:0] RATE_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] RATE_MIN = 32'h8000_0000;

endpackage

[design/qdps_if.sv]
// Valid/ready channel interfaces: item in, result out, register write.
// Depends on qdps_pkg for field widths.
interface qdps_in_if;
  logic                          valid;
  logic                          ready;
  logic [qdps_pkg::ACT_W-1:0]    action;
  logic                          edge_channel;
  logic                          level_a;
  logic                          level_b;
  logic [qdps_pkg::TIME_W-1:0]   time_now;

  modport source (output valid, action, edge_channel, level_a, level_b, time_now,
                  input ready);
  modport sink   (input valid, action, edge_channel, level_a, level_b, time_now,
                  output ready);
endinterface

interface qdps_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qdps_pkg::DATA_W-1:0] position;
  logic        [qdps_pkg::DATA_W-1:0] edge_total;
  logic signed [qdps_pkg::DATA_W-1:0] count_delta;
  logic signed [qdps_pkg::DATA_W-1:0] rate;
  logic                               rate_valid;
  logic        [qdps_pkg::DIR_W-1:0]  direction;

  modport source (output valid, position, edge_total, count_delta, rate, rate_valid,
                  direction, input ready);
  modport sink   (input valid, position, edge_total, count_delta, rate, rate_valid,
                  direction, output ready);
endinterface

interface qdps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [qdps_pkg::CFG_IDX_W-1:0]   index;
  logic [qdps_pkg::DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/quadrature_decoder_period_speed.sv]
// Quadrature decoder with period-based rate: position, edge total, delta and
// a Q16.16 rate from a ring of edge timestamps. Uses qdps_pkg and qdps_if.
//
//  channel    dir  handshake     carries
//  item_i     in   valid/ready   action, edge_channel, level_a, level_b, time_now
//  result_o   out  valid/ready   position, edge_total, count_delta, rate,
//                                rate_valid, direction
//  cfg_i      in   valid/ready   index (0 rate_scale, 1 stall_timeout), data
//
// Each request passes through state update, ring read, scale/stall prep,
// span, then one quotient bit per cycle from the restoring divider, then
// saturation. With no valid rate the divider is skipped.
// item_i.ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next request can be taken while it waits.
// If the previous result is still not taken, the final step holds.
// rst_ni clears counters, direction, ring control and registers to their
// defaults; the timestamp ring itself is not cleared. cfg_i is always ready.
module quadrature_decoder_period_speed (
  input  logic               clk_i,
  input  logic               rst_ni,
  qdps_in_if.sink            item_i,
  qdps_out_if.source         result_o,
  qdps_cfg_if.sink           cfg_i
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;  // counters, ring write
  localparam logic [2:0] S_RD   = 3'd2;  // ring read (oldest, newest)
  localparam logic [2:0] S_PREP = 3'd3;  // stall check, scale magnitude * (depth-1)
  localparam logic [2:0] S_SPAN = 3'd4;  // span, rate qualifiers, divider load
  localparam logic [2:0] S_DIV  = 3'd5;  // one quotient bit per cycle
  localparam logic [2:0] S_FIN  = 3'd6;  // saturate, load output register

  localparam int DW = qdps_pkg::DATA_W;
  localparam int TW = qdps_pkg::TIME_W;
  localparam int NW = qdps_pkg::NUM_W;
  localparam int XW = qdps_pkg::IDX_W;
  localparam int CW = qdps_pkg::CNT_W;

  logic [2:0] state_q, state_d;

  // Config registers
  logic [DW-1:0] rate_scale_q;
  logic [TW-1:0] stall_timeout_q;

  // Captured request
  logic [qdps_pkg::ACT_W-1:0] act_q;
  logic                       fwd_q;
  logic [TW-1:0]              now_q;

  // Decoder state
  logic [DW-1:0]              pos_q;
  logic [DW-1:0]              edges_q;
  logic [DW-1:0]              snap_q;
  logic [qdps_pkg::DIR_W-1:0] dir_q;
  logic [XW-1:0]              ring_idx_q;
  logic                       ring_full_q;

  // Ring memory and its registered reads
  logic [TW-1:0] ring_mem [qdps_pkg::RING_DEPTH];
  logic [TW-1:0] oldest_q, newest_raw_q, newest_q;

  // Rate datapath
  logic [NW-1:0] num_q;
  logic [TW-1:0] span_q;
  logic [NW-1:0] dvd_q;
  logic [TW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          rate_ok_q;

  // Output register
  logic          out_valid_q;
  logic [DW-1:0] out_pos_q, out_edges_q, out_delta_q, out_rate_q;
  logic          out_rvalid_q;
  logic [qdps_pkg::DIR_W-1:0] out_dir_q;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_fire, out_load;

  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign in_fire      = item_i.valid && item_i.ready;
  // final step may load when the slot is empty or being drained this cycle
  assign out_load     = (state_q == S_FIN) && (!out_valid_q || result_o.ready);

  // ---------------------------------------------------------------------------
  // Edge update: a direction change restarts the ring before this write
  // ---------------------------------------------------------------------------
  logic [qdps_pkg::DIR_W-1:0] edge_dir;
  logic                       dir_change;
  logic [XW-1:0]              wr_idx;
  logic                       base_full;
  logic                       wr_last;
  logic [XW-1:0]              next_idx;
  logic                       ring_we;

  assign edge_dir   = fwd_q ? qdps_pkg::DIR_FWD : qdps_pkg::DIR_REV;
  assign dir_change = (dir_q != edge_dir);
  assign wr_idx     = dir_change ? '0 : ring_idx_q;
  assign base_full  = dir_change ? 1'b0 : ring_full_q;
  assign wr_last    = (wr_idx == XW'(qdps_pkg::RING_DEPTH - 1));
  assign next_idx   = wr_last ? '0 : XW'(wr_idx + XW'(1));
  assign ring_we    = (state_q == S_UPD) && (act_q == qdps_pkg::ACT_EDGE);

  // newest entry sits just behind the write index
  logic [XW-1:0] newest_idx;
  assign newest_idx = (ring_idx_q == '0) ? XW'(qdps_pkg::RING_DEPTH - 1)
                                         : XW'(ring_idx_q - XW'(1));

  // ---------------------------------------------------------------------------
  // Prep: stall replacement and numerator
  // ---------------------------------------------------------------------------
  logic          scale_neg;
  logic [DW-1:0] scale_mag;
  logic [NW-1:0] num_w;
  logic [TW-1:0] idle_ticks;
  logic [TW-1:0] span_w;

  assign scale_neg  = rate_scale_q[DW-1];
  // two's complement of 0x80000000 is itself, which is the right magnitude
  assign scale_mag  = scale_neg ? DW'(~rate_scale_q + DW'(1)) : rate_scale_q;
  assign num_w      = NW'(scale_mag) * NW'(qdps_pkg::RING_DEPTH - 1);
  assign idle_ticks = now_q - newest_raw_q;
  assign span_w     = newest_q - oldest_q;

  // ---------------------------------------------------------------------------
  // Restoring divider step
  // ---------------------------------------------------------------------------
  logic [TW:0]   rem_sh;
  logic          rem_ge;
  logic [TW:0]   rem_sub;

  assign rem_sh  = {rem_q, dvd_q[NW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, span_q});
  assign rem_sub = rem_sh - {1'b0, span_q};

  // ---------------------------------------------------------------------------
  // Saturation: sign from scale, flipped for reverse travel
  // ---------------------------------------------------------------------------
  logic          rate_neg;
  logic [DW-1:0] rate_sat;

  assign rate_neg = scale_neg ^ (dir_q == qdps_pkg::DIR_REV);

  always_comb begin
    if (rate_neg) begin
      if (dvd_q >= NW'(qdps_pkg::RATE_MIN)) begin
        rate_sat = qdps_pkg::RATE_MIN;
      end else begin
        rate_sat = DW'(~dvd_q[DW-1:0] + DW'(1));
      end
    end else begin
      if (dvd_q >= NW'(qdps_pkg::RATE_MAX)) begin
        rate_sat = qdps_pkg::RATE_MAX;
      end else begin
        rate_sat = dvd_q[DW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_UPD;
      S_UPD:   state_d = S_RD;
      S_RD:    state_d = S_PREP;
      S_PREP:  state_d = S_SPAN;
      S_SPAN: begin
        if (ring_full_q && (dir_q != qdps_pkg::DIR_NONE) && (span_w != '0)) begin
          state_d = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV:   if (cnt_q == '0) state_d = S_FIN;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_scale_q    <= qdps_pkg::RATE_SCALE_RST;
      stall_timeout_q <= qdps_pkg::STALL_TIMEOUT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == qdps_pkg::CFG_RATE_SCALE) begin
        rate_scale_q <= cfg_i.data;
      end else if (cfg_i.index == qdps_pkg::CFG_STALL_TIMEOUT) begin
        stall_timeout_q <= cfg_i.data;
      end
    end
  end

  // Request capture; direction bit 1 = forward
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= item_i.action;
      fwd_q <= item_i.level_a ^ item_i.level_b ^ item_i.edge_channel;
      now_q <= item_i.time_now;
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      edges_q     <= '0;
      snap_q      <= '0;
      dir_q       <= qdps_pkg::DIR_NONE;
      ring_idx_q  <= '0;
      ring_full_q <= 1'b0;
    end else if (state_q == S_UPD) begin
      if (act_q == qdps_pkg::ACT_EDGE) begin
        pos_q       <= fwd_q ? DW'(pos_q + DW'(1)) : DW'(pos_q - DW'(1));
        edges_q     <= DW'(edges_q + DW'(1));
        dir_q       <= edge_dir;
        ring_idx_q  <= next_idx;
        ring_full_q <= base_full | wr_last;
      end else if (act_q == qdps_pkg::ACT_SNAP) begin
        snap_q <= pos_q;
      end
    end
  end

  // Timestamp ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wr_idx] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      oldest_q     <= ring_mem[ring_idx_q];
      newest_raw_q <= ring_mem[newest_idx];
    end
  end

  // Rate datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_PREP) begin
      newest_q <= (idle_ticks >= stall_timeout_q) ? now_q : newest_raw_q;
      num_q    <= num_w;
    end
    if (state_q == S_SPAN) begin
      span_q <= span_w;
      dvd_q  <= num_q;
      rem_q  <= '0;
      cnt_q  <= CW'(NW - 1);
    end else if (state_q == S_DIV) begin
      rem_q <= rem_ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
      dvd_q <= {dvd_q[NW-2:0], rem_ge};
      cnt_q <= CW'(cnt_q - CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_ok_q <= 1'b0;
    end else if (state_q == S_SPAN) begin
      rate_ok_q <= (state_d == S_DIV);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q    <= pos_q;
      out_edges_q  <= edges_q;
      out_delta_q  <= DW'(pos_q - snap_q);
      out_rate_q   <= rate_ok_q ? rate_sat : '0;
      out_rvalid_q <= rate_ok_q;
      out_dir_q    <= dir_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.position    = out_pos_q;
  assign result_o.edge_total  = out_edges_q;
  assign result_o.count_delta = out_delta_q;
  assign result_o.rate        = out_rate_q;
  assign result_o.rate_valid  = out_rvalid_q;
  assign result_o.direction   = out_dir_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a full ring only exists once some direction has been seen
  a_full_has_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_full_q |-> (dir_q != qdps_pkg::DIR_NONE))
    else $error("ring full with no direction");

  // partial remainder stays below the divisor through the division
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < span_q))
    else $error("divider remainder out of range");

  // an unqualified rate must read as zero
  a_rate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.rate_valid) |-> (result_o.rate == '0))
    else $error("rate nonzero while not valid");

  // divider is only entered with a nonzero span
  a_span_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SPAN) && (state_d == S_DIV)) |=> (span_q != '0))
    else $error("division by zero span");

endmodule
